// ===== sv/slot_free_stack_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// slot free stack allocator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SLOT_FREE_STACK_ALLOCATOR_DEFINES_SVH
`define SLOT_FREE_STACK_ALLOCATOR_DEFINES_SVH

// property that must hold at every edge out of reset
`define SFSA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfsa_pkg
// types and fixed constants of the slot free stack allocator
// ----------------------------------------------------------------------------
package sfsa_pkg;

    localparam int OFF_W     = 21;
    localparam int SIZE_W    = 13;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 1;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b1;

    localparam logic [SIZE_W-1:0]  SLOT_BYTES_RST   = 13'd64;
    localparam logic [COUNT_W-1:0] SLOTS_IN_USE_RST = 9'd256;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_POP,
        B_MUL,
        B_SUM,
        B_DIV,
        B_DONE
    } back_state_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [OFF_W-1:0] body;
    } cmd_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  slot_bytes;
        logic [COUNT_W-1:0] slots_in_use;
    } cfg_t;

endpackage

// ===== sv/sfsa_div.sv =====
// ----------------------------------------------------------------------------
// sfsa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sfsa_div
    import sfsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [OFF_W-1:0]  dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [OFF_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(OFF_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [OFF_W-1:0]  dq_reg, dq_next;
    logic [SIZE_W:0]   trial;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[OFF_W-1]};
        ge        = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(OFF_W);
            rem_next  = '0;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
            dq_next  = {dq_reg[OFF_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== sv/sfsa_front.sv =====
// ----------------------------------------------------------------------------
// sfsa_front
// input side: strips the header from the offset and queues the command
// ----------------------------------------------------------------------------
module sfsa_front
    import sfsa_pkg::*;
#(
    parameter int HEADER_BYTES = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             command,
    input  logic [OFF_W-1:0] slot_offset,
    output logic             q_valid,
    output cmd_item_t        q_item,
    input  logic             q_pop
);

    localparam logic [OFF_W-1:0] HDR = OFF_W'(HEADER_BYTES);

    cmd_item_t         q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_item_t         new_item;
    logic              push;
    logic              pop;

    always_comb
    begin
        new_item.cmd  = cmd_t'(command);
        // body offset saturates at zero below the header
        new_item.body = (slot_offset >= HDR) ? slot_offset - HDR : '0;
        in_ready      = cnt_reg != QCNT_W'(QDEPTH);
        q_valid       = cnt_reg != '0;
        push          = in_valid && in_ready;
        pop           = q_pop && q_valid;
        wr_ptr_next   = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next   = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next      = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign q_item = q_mem_reg[rd_ptr_reg];

endmodule

// ===== sv/sfsa_back.sv =====
// ----------------------------------------------------------------------------
// sfsa_back
// execution side: free stack, fresh counter, offset math and result register
// ----------------------------------------------------------------------------
`include "slot_free_stack_allocator_defines.svh"

module sfsa_back
    import sfsa_pkg::*;
#(
    parameter int MAX_SLOTS    = 256,
    parameter int HEADER_BYTES = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             q_valid,
    input  cmd_item_t        q_item,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [OFF_W-1:0] given_offset,
    output logic             now_full,
    output logic             now_empty
);

    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int PW   = SIZE_W + SW;
    localparam int SUMW = ((PW > OFF_W) ? PW : OFF_W) + 1;

    back_state_t       state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     fresh_reg, fresh_next;
    status_t           status_reg, status_next;
    logic [SW-1:0]     num_reg, num_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [OFF_W-1:0]  given_reg, given_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [OFF_W-1:0]  out_given_reg;
    logic              out_full_reg;
    logic              out_empty_reg;

    logic [SW-1:0]     stack_mem [MAX_SLOTS];
    logic [SW-1:0]     mem_rd_reg;
    logic              mem_we;
    logic              mem_re;
    logic [SW-1:0]     mem_waddr;
    logic [SW-1:0]     mem_raddr;
    logic [SW-1:0]     mem_wdata;

    logic [SIZE_W-1:0] eff_size;
    logic [CW-1:0]     eff_count;
    logic [CW-1:0]     untouched;
    logic [CW:0]       free_cnt;
    logic              is_full;
    logic              is_empty;
    logic              stack_top;
    logic              load_out;
    logic              div_start;
    logic              div_done;
    logic [OFF_W-1:0]  div_quot;
    logic [SW-1:0]     quot_sat;
    logic [CW-1:0]     fill_dec;

    sfsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_item.body),
        .divisor  (eff_size),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        eff_size  = (cfg.slot_bytes == '0) ? SIZE_W'(1) : cfg.slot_bytes;
        eff_count = (32'(cfg.slots_in_use) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
                                                             : CW'(cfg.slots_in_use);
        untouched = (fresh_reg < eff_count) ? eff_count - fresh_reg : '0;
        free_cnt  = {1'b0, fill_reg} + {1'b0, untouched};
        is_full   = free_cnt == '0;
        is_empty  = free_cnt >= {1'b0, eff_count};
        stack_top = 32'(fill_reg) >= 32'(MAX_SLOTS);
        fill_dec  = fill_reg - 1'b1;
        quot_sat  = (32'(div_quot) > 32'(MAX_SLOTS - 1)) ? SW'(MAX_SLOTS - 1)
                                                         : SW'(div_quot);
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        fresh_next     = fresh_reg;
        status_next    = status_reg;
        num_next       = num_reg;
        prod_next      = prod_reg;
        given_next     = given_reg;
        out_valid_next = out_valid_reg && !out_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = fill_reg[SW-1:0];
        mem_raddr      = fill_dec[SW-1:0];
        mem_wdata      = quot_sat;
        div_start      = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    status_next = ST_OK;
                    given_next  = '0;
                    if (q_item.cmd == CMD_ALLOC)
                    begin
                        if (fill_reg != '0)
                        begin
                            mem_re     = 1'b1;
                            fill_next  = fill_dec;
                            state_next = B_POP;
                        end
                        else if (fresh_reg < eff_count)
                        begin
                            num_next   = SW'(fresh_reg);
                            fresh_next = fresh_reg + 1'b1;
                            state_next = B_MUL;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                            state_next  = B_DONE;
                        end
                    end
                    else if (is_empty || stack_top)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = B_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = B_DIV;
                    end
                end
            end
            B_POP:
            begin
                num_next   = mem_rd_reg;
                state_next = B_MUL;
            end
            B_MUL:
            begin
                prod_next  = PW'(eff_size) * PW'(num_reg);
                state_next = B_SUM;
            end
            B_SUM:
            begin
                given_next = OFF_W'(SUMW'(HEADER_BYTES) + SUMW'(prod_reg));
                state_next = B_DONE;
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        num_reg    <= num_next;
        prod_reg   <= prod_next;
        given_reg  <= given_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_given_reg  <= given_reg;
            out_full_reg   <= is_full;
            out_empty_reg  <= is_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rd_reg <= stack_mem[mem_raddr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign given_offset = out_given_reg;
    assign now_full     = out_full_reg;
    assign now_empty    = out_empty_reg;

    `SFSA_ASSERT_ALWAYS(a_fill_bound, 32'(fill_reg) <= 32'(MAX_SLOTS), "stack fill past depth")
    `SFSA_ASSERT_NEXT(a_push_fill, mem_we, fill_reg == $past(fill_reg) + 1'b1,
        "push did not grow stack")
    `SFSA_ASSERT_NEXT(a_pop_fill, mem_re,
        fill_reg == $past(fill_reg) - 1'b1 && state_reg == B_POP, "pop did not shrink stack")
    `SFSA_ASSERT_NEXT(a_no_overwrite, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_given_reg) && $stable(out_status_reg),
        "pending result overwritten")

endmodule

// ===== sv/slot_free_stack_allocator.sv =====
// ----------------------------------------------------------------------------
// slot_free_stack_allocator
// fixed-size slot allocator: free stack of released slots plus fresh counter
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | to block  | in_valid / in_ready  | command, slot_offset
//  out     | from blk  | out_valid/ out_ready | status, given_offset, now_full,
//          |           |                      | now_empty
//  cfg     | to block  | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
//  an allocate item: stack read if a slot is free on it, one multiply, one add
//  a free item runs a bit-serial divide of the body offset by the slot size
//  (one quotient bit per cycle over 21 bits)
//  items run one at a time in the back end; a 2-entry queue keeps accepting
//  while a result waits in the output register, so stalls stay local
//  reset clears the stack fill, fresh counter and queue at once: no sweep
//
module slot_free_stack_allocator
    import sfsa_pkg::*;
#(
    parameter int MAX_SLOTS    = 256,
    parameter int HEADER_BYTES = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [OFF_W-1:0]     slot_offset,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [OFF_W-1:0]     given_offset,
    output logic                 now_full,
    output logic                 now_empty,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      q_valid;
    logic      q_pop;
    cmd_item_t q_item;

    // config writes land in the next cycle, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SLOT_BYTES:   cfg_next.slot_bytes   = cfg_data;
                REG_SLOTS_IN_USE: cfg_next.slots_in_use = cfg_data[COUNT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_bytes   <= SLOT_BYTES_RST;
            cfg_reg.slots_in_use <= SLOTS_IN_USE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: header strip and command queue
    sfsa_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .slot_offset (slot_offset),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // back: stack, fresh counter, divide / multiply, result register
    sfsa_back #(
        .MAX_SLOTS    (MAX_SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .given_offset (given_offset),
        .now_full     (now_full),
        .now_empty    (now_empty)
    );

endmodule

// ===== bench/slot_free_stack_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_free_stack_allocator_tb
// self-checking bench: a short directed table followed by random phases of
// allocate/free traffic, results held to typed answers or a local allocator model
// ----------------------------------------------------------------------------
module slot_free_stack_allocator_tb;
    import sfsa_pkg::*;

    localparam int SLOT_LIMIT    = 256;
    localparam int HEADER_LEN    = 32;
    localparam int RUN_LIMIT     = 500000;
    localparam int SETTLE_CYCLES = 40;

    // one result item as the block presents it
    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] given_offset;
        logic             now_full;
        logic             now_empty;
    } alloc_result_t;

    // one line of the directed table: a register write or a command item
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [SIZE_W-1:0]    reg_val;
        cmd_t                 cmd;
        logic [OFF_W-1:0]     off;
        bit                   typed;
        alloc_result_t        want;
    } stim_row_t;

    typedef enum {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL_RATE
    } pace_t;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 command     = 1'b0;
    logic [OFF_W-1:0]     slot_offset = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [1:0]           status;
    logic [OFF_W-1:0]     given_offset;
    logic                 now_full;
    logic                 now_empty;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [SIZE_W-1:0]    cfg_data    = '0;

    // typed expectation travels with the payload of a directed item
    bit                   drive_typed = 1'b0;
    alloc_result_t        drive_want  = '0;

    // allocator model state
    logic [7:0]           model_stack [SLOT_LIMIT];
    int                   model_fill  = 0;
    int                   model_fresh = 0;
    logic [SIZE_W-1:0]    size_reg    = SLOT_BYTES_RST;
    logic [COUNT_W-1:0]   count_reg   = SLOTS_IN_USE_RST;

    alloc_result_t        expected_results [$];
    stim_row_t            directed_rows [$];
    int                   held_slots [$];
    logic [OFF_W-1:0]     last_freed_off = '0;
    bit                   freed_once     = 1'b0;

    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   mismatch_count = 0;
    int                   cycle_count    = 0;

    slot_free_stack_allocator #(
        .MAX_SLOTS    (SLOT_LIMIT),
        .HEADER_BYTES (HEADER_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .slot_offset  (slot_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .given_offset (given_offset),
        .now_full     (now_full),
        .now_empty    (now_empty),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // allocator model
    // ------------------------------------------------------------------

    // slot count as the block sees it: anything above the stack depth clamps
    function automatic int page_slots();
        return (count_reg > SLOT_LIMIT) ? SLOT_LIMIT : int'(count_reg);
    endfunction

    // freed slots on the stack plus slots never handed out
    function automatic int free_slot_count();
        int n;
        begin
            n = page_slots();
            return model_fill + ((model_fresh < n) ? n - model_fresh : 0);
        end
    endfunction

    // advance the model by one command item and return its result
    function automatic alloc_result_t apply_command(input cmd_t cmd,
                                                    input logic [OFF_W-1:0] off);
        alloc_result_t r;
        int            n;
        int            sz;
        int            num;
        int            body;
        bit            granted;
        begin
            n       = page_slots();
            sz      = (size_reg == 0) ? 1 : int'(size_reg);
            r       = '0;
            r.status = ST_OK;
            granted = 1'b1;
            num     = 0;
            if (cmd == CMD_ALLOC)
            begin
                // recycled slots first, then the fresh counter
                if (model_fill > 0)
                begin
                    model_fill = model_fill - 1;
                    num = model_stack[model_fill];
                end
                else if (model_fresh < n)
                begin
                    num = model_fresh;
                    model_fresh = model_fresh + 1;
                end
                else
                    granted = 1'b0;
                if (granted)
                begin
                    r.given_offset = OFF_W'(HEADER_LEN + sz * num);
                    held_slots.push_back(num);
                end
                else
                    r.status = ST_FULL;
            end
            else
            begin
                // nothing outstanding, or the stack already at depth
                if (free_slot_count() >= n || model_fill >= SLOT_LIMIT)
                    r.status = ST_EMPTY;
                else
                begin
                    body = (off >= HEADER_LEN) ? int'(off) - HEADER_LEN : 0;
                    num  = body / sz;
                    if (num > SLOT_LIMIT - 1)
                        num = SLOT_LIMIT - 1;
                    model_stack[model_fill] = 8'(num);
                    model_fill = model_fill + 1;
                end
            end
            r.now_full  = (free_slot_count() == 0);
            r.now_empty = (free_slot_count() >= n);
            return r;
        end
    endfunction

    // ------------------------------------------------------------------
    // acceptance monitor: predicts on every accepted item, tracks registers
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : accept_monitor
        alloc_result_t predicted;
        if (rst_n && in_valid && in_ready)
        begin
            predicted = apply_command(cmd_t'(command), slot_offset);
            // directed rows with a hand-typed answer are held to that answer
            expected_results.push_back(drive_typed ? drive_want : predicted);
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_SLOT_BYTES)
                size_reg <= cfg_data;
            else if (cfg_index == REG_SLOTS_IN_USE)
                count_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d offset %0d", $time,
                         status, given_offset);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("given_offset", 32'(want.given_offset), 32'(given_offset));
                check_field("now_full", 32'(want.now_full), 32'(now_full));
                check_field("now_empty", 32'(want.now_empty), 32'(now_empty));
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("slot_free_stack_allocator regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SLOW_SINK:
            begin
                send_idle_pct  = 34;
                recv_stall_pct = 87;
            end
            PACE_SLOW_SOURCE:
            begin
                send_idle_pct  = 87;
                recv_stall_pct = 34;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // present one item, holding it until accepted; valid stays up on return
    task automatic send_item(input cmd_t cmd, input logic [OFF_W-1:0] off,
                             input bit typed, input alloc_result_t want);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            command     <= cmd;
            slot_offset <= off;
            drive_typed <= typed;
            drive_want  <= want;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
        end
    endtask

    // register write, only ever issued with the block drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // stop sending, wait for every outstanding result, then let the divider settle
    task automatic drain_block();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table helpers
    // ------------------------------------------------------------------
    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [SIZE_W-1:0] val);
        stim_row_t row;
        begin
            row         = '{cmd: CMD_ALLOC, default: '0};
            row.is_cfg  = 1'b1;
            row.reg_idx = idx;
            row.reg_val = val;
            directed_rows.push_back(row);
        end
    endfunction

    function automatic void add_item(input cmd_t cmd, input logic [OFF_W-1:0] off);
        stim_row_t row;
        begin
            row     = '{cmd: CMD_ALLOC, default: '0};
            row.cmd = cmd;
            row.off = off;
            directed_rows.push_back(row);
        end
    endfunction

    function automatic void add_typed(input cmd_t cmd, input logic [OFF_W-1:0] off,
                                      input status_t st, input logic [OFF_W-1:0] given,
                                      input logic full, input logic empty);
        stim_row_t row;
        begin
            row                   = '{cmd: CMD_ALLOC, default: '0};
            row.cmd               = cmd;
            row.off               = off;
            row.typed             = 1'b1;
            row.want.status       = st;
            row.want.given_offset = given;
            row.want.now_full     = full;
            row.want.now_empty    = empty;
            directed_rows.push_back(row);
        end
    endfunction

    // ------------------------------------------------------------------
    // random phase: program both registers, then a stream of commands
    // frees mostly return slots that are actually held, the rest are double
    // frees and arbitrary offsets
    // ------------------------------------------------------------------
    task automatic run_phase(input int size, input int count, input int items,
                             input int alloc_pct, input pace_t pace);
        int               sz;
        int               idx;
        int               num;
        int               pick;
        int               i;
        logic [OFF_W-1:0] off;
        alloc_result_t    none;
        begin
            drain_block();
            write_reg(REG_SLOT_BYTES, SIZE_W'(size));
            write_reg(REG_SLOTS_IN_USE, SIZE_W'(count));
            set_pace(pace);
            none = '0;
            sz   = (size == 0) ? 1 : size;
            for (i = 0; i < items; i++)
            begin
                if ($urandom_range(0, 99) < alloc_pct)
                    // offset is don't-care on allocate, so toss it fully random
                    send_item(CMD_ALLOC, OFF_W'($urandom_range(0, (1 << OFF_W) - 1)),
                              1'b0, none);
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (held_slots.size() > 0 && pick < 75)
                    begin
                        idx = $urandom_range(0, held_slots.size() - 1);
                        num = held_slots[idx];
                        held_slots.delete(idx);
                        off = OFF_W'(HEADER_LEN + sz * num);
                        // sometimes point into the middle of the slot
                        if (sz > 1 && $urandom_range(0, 3) == 0)
                            off = off + OFF_W'($urandom_range(0, sz - 1));
                    end
                    else if (freed_once && pick < 85)
                        off = last_freed_off;
                    else
                        off = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
                    last_freed_off = off;
                    freed_once     = 1'b1;
                    send_item(CMD_FREE, off, 1'b0, none);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t row;

        // page starts empty, 64 byte slots, 256 slots
        add_typed(CMD_FREE,  32,       ST_EMPTY, 0,  1'b0, 1'b1); // free with all slots free
        add_typed(CMD_ALLOC, 0,        ST_OK,    32, 1'b0, 1'b0); // first fresh slot
        add_typed(CMD_ALLOC, 2097151,  ST_OK,    96, 1'b0, 1'b0); // offset ignored
        add_typed(CMD_FREE,  96,       ST_OK,    0,  1'b0, 1'b0);
        add_typed(CMD_ALLOC, 0,        ST_OK,    96, 1'b0, 1'b0); // recycled from stack
        add_item(CMD_FREE,  0);        // below header, lands on slot 0
        add_item(CMD_FREE,  1048608);  // slot number saturates to top slot
        add_item(CMD_ALLOC, 0);
        add_item(CMD_ALLOC, 0);
        add_item(CMD_FREE,  31);       // just under the header
        add_item(CMD_ALLOC, 0);
        add_cfg(REG_SLOT_BYTES, 0);    // zero size behaves as one byte
        add_item(CMD_ALLOC, 0);
        add_item(CMD_FREE,  1048575);
        add_item(CMD_ALLOC, 0);
        add_cfg(REG_SLOT_BYTES, 8191); // widest slot size
        add_item(CMD_ALLOC, 0);
        add_cfg(REG_SLOTS_IN_USE, 0);  // zero slots: full and empty at once
        add_typed(CMD_ALLOC, 0,  ST_FULL,  0, 1'b1, 1'b1);
        add_typed(CMD_FREE,  32, ST_EMPTY, 0, 1'b1, 1'b1);
        add_cfg(REG_SLOTS_IN_USE, 8191); // upper data bits drop, count clamps
        add_item(CMD_ALLOC, 0);
        add_cfg(REG_SLOTS_IN_USE, 2);  // fresh counter already past the count
        add_typed(CMD_ALLOC, 0, ST_FULL, 0, 1'b1, 1'b0);
        add_item(CMD_FREE, 8223);
        add_item(CMD_FREE, 8223);      // double free goes unnoticed
        add_typed(CMD_FREE, 8223, ST_EMPTY, 0, 1'b0, 1'b1);
        add_item(CMD_ALLOC, 0);
        add_item(CMD_ALLOC, 0);

        set_pace(PACE_SLOW_SINK);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.is_cfg)
            begin
                drain_block();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                send_item(row.cmd, row.off, row.typed, row.want);
        end

        // slow sink
        run_phase(64, 8, 120, 70, PACE_SLOW_SINK);
        run_phase(0, 1, 60, 60, PACE_SLOW_SINK);
        run_phase(4096, 256, 150, 95, PACE_SLOW_SINK);
        // slow source; fill the big page to the top, then drain it back
        run_phase(4096, 256, 150, 95, PACE_SLOW_SOURCE);
        run_phase(1, 256, 150, 5, PACE_SLOW_SOURCE);
        run_phase(8191, 300, 150, 5, PACE_SLOW_SOURCE);
        // full rate
        run_phase($urandom_range(1, 4096), $urandom_range(1, 16), 150, 55, PACE_FULL_RATE);
        run_phase(3, 2, 120, 50, PACE_FULL_RATE);
        run_phase($urandom_range(1, 4096), 5, 120, 50, PACE_FULL_RATE);
        run_phase(64, 256, 60, 50, PACE_FULL_RATE);

        drain_block();
        if (mismatch_count == 0)
            $display("slot_free_stack_allocator regression: pass");
        else
            $display("slot_free_stack_allocator regression: fail");
        $finish;
    end

endmodule
